[src/hfps_pkg.sv]
`default_nettype none

package hfps_pkg;

    // Configuration register widths
    localparam int GRID_ROWS_W = 11;
    localparam int GRID_COLS_W = 9;
    localparam int COEF_W      = 16;

    // APB decode
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 2;

    // Register map, one word per register
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_ROWS = 2'd0,
        REG_GRID_COLS = 2'd1,
        REG_COEF_X    = 2'd2,
        REG_COEF_Y    = 2'd3
    } reg_idx_t;

    // Reset values of the registers
    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST = 11'd8;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 9'd8;
    localparam logic [COEF_W-1:0]      COEF_RST      = 16'd0;

    // Fixed point: coefficients are Q0.16, round half up
    localparam int FRAC_BITS = 16;

    // Per-item control that travels with the update pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } hfps_tag_t;

endpackage

`default_nettype wire

[src/hfps_update.sv]
`default_nettype none

module hfps_update #(
    parameter int TEMP_WIDTH = 32
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    advance,
    input  wire hfps_pkg::hfps_tag_t               tag_in,
    input  wire signed [TEMP_WIDTH-1:0]            up,
    input  wire signed [TEMP_WIDTH-1:0]            centre,
    input  wire signed [TEMP_WIDTH-1:0]            down,
    input  wire signed [TEMP_WIDTH-1:0]            left,
    input  wire signed [TEMP_WIDTH-1:0]            right,
    input  wire        [hfps_pkg::COEF_W-1:0]      coef_x,
    input  wire        [hfps_pkg::COEF_W-1:0]      coef_y,
    output hfps_pkg::hfps_tag_t                    tag_out,
    output logic signed [TEMP_WIDTH-1:0]           temp_out
);

    localparam int DW = TEMP_WIDTH + 2;                 // second difference
    localparam int CW = hfps_pkg::COEF_W + 1;           // coefficient as signed
    localparam int PW = DW + CW;                        // one product
    localparam int SW = PW + 1;                         // sum of products
    localparam int RW = SW - hfps_pkg::FRAC_BITS;       // scaled sum
    localparam int TW = RW + 1;                         // centre plus scaled sum
    localparam logic signed [SW-1:0] ROUND_HALF =
        SW'(1) <<< (hfps_pkg::FRAC_BITS - 1);
    localparam logic signed [TW-1:0] SAT_MAX =
        {{(TW-TEMP_WIDTH+1){1'b0}}, {(TEMP_WIDTH-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_MIN =
        {{(TW-TEMP_WIDTH+1){1'b1}}, {(TEMP_WIDTH-1){1'b0}}};

    hfps_pkg::hfps_tag_t          s1_tag_reg;
    hfps_pkg::hfps_tag_t          s2_tag_reg;
    hfps_pkg::hfps_tag_t          out_tag_reg;
    logic signed [DW-1:0]         s1_dxx_reg;
    logic signed [DW-1:0]         s1_dyy_reg;
    logic signed [TEMP_WIDTH-1:0] s1_centre_reg;
    logic signed [PW-1:0]         s2_px_reg;
    logic signed [PW-1:0]         s2_py_reg;
    logic signed [TEMP_WIDTH-1:0] s2_centre_reg;
    logic signed [TEMP_WIDTH-1:0] temp_out_reg;

    logic signed [DW-1:0]         dxx;
    logic signed [DW-1:0]         dyy;
    logic signed [CW-1:0]         cx_s;
    logic signed [CW-1:0]         cy_s;
    logic signed [SW-1:0]         sum_w;
    logic signed [RW-1:0]         scaled;
    logic signed [TW-1:0]         total;
    logic signed [TEMP_WIDTH-1:0] sat_val;

    // Second differences in both directions
    always_comb
    begin
        dxx = DW'(up) + DW'(down) - (DW'(centre) <<< 1);
        dyy = DW'(left) + DW'(right) - (DW'(centre) <<< 1);
    end

    // Stage 1: register the differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else if (advance)
        begin
            s1_tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dxx_reg    <= dxx;
            s1_dyy_reg    <= dyy;
            s1_centre_reg <= centre;
        end
    end

    // Stage 2: weight each difference by its coefficient
    assign cx_s = $signed({1'b0, coef_x});
    assign cy_s = $signed({1'b0, coef_y});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
        end
        else if (advance)
        begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_px_reg     <= PW'(cx_s) * PW'(s1_dxx_reg);
            s2_py_reg     <= PW'(cy_s) * PW'(s1_dyy_reg);
            s2_centre_reg <= s1_centre_reg;
        end
    end

    // Stage 3: round to the sample grid, add centre, saturate
    always_comb
    begin
        sum_w  = SW'(s2_px_reg) + SW'(s2_py_reg) + ROUND_HALF;
        scaled = $signed(sum_w[SW-1:hfps_pkg::FRAC_BITS]);
        total  = TW'(s2_centre_reg) + TW'(scaled);
        if (total > SAT_MAX)
        begin
            sat_val = SAT_MAX[TEMP_WIDTH-1:0];
        end
        else if (total < SAT_MIN)
        begin
            sat_val = SAT_MIN[TEMP_WIDTH-1:0];
        end
        else
        begin
            sat_val = total[TEMP_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else if (advance)
        begin
            out_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            temp_out_reg <= sat_val;
        end
    end

    assign tag_out  = out_tag_reg;
    assign temp_out = temp_out_reg;

endmodule

`default_nettype wire

[src/heat_five_point_stencil.sv]
`default_nettype none

// Channel   Signals                                   Transfer
// apb       psel penable pwrite paddr pwdata prdata   psel & penable & pwrite & pready
// sample    sample_valid sample_ready temp_in         sample_valid & sample_ready
// result    result_valid result_ready temp_out        result_valid & result_ready
//           frame_last
//
// One sample a cycle; the line memories take one write and one read per transfer.
// After the sample below its point is transferred, a result passes stages 1, 2 and 3.
// After reset both line memories are cleared, one entry a cycle over all MAX_COLS + 2
// entries with sample_ready low; configuration writes are taken during the sweep.
// A stalled result holds the whole update pipeline and drops sample_ready.
module heat_five_point_stencil #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 1024,
    parameter int TEMP_WIDTH = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [hfps_pkg::PADDR_W-1:0]        paddr,
    input  wire  [hfps_pkg::PDATA_W-1:0]        pwdata,
    output logic [hfps_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  wire                                 sample_valid,
    output logic                                sample_ready,
    input  wire  signed [TEMP_WIDTH-1:0]        temp_in,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output logic signed [TEMP_WIDTH-1:0]        temp_out,
    output logic                                frame_last
);

    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int ROW_W      = $clog2(MAX_ROWS + 2);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(LINE_DEPTH - 1);

    // Configuration
    logic [hfps_pkg::GRID_ROWS_W-1:0] grid_rows_reg;
    logic [hfps_pkg::GRID_COLS_W-1:0] grid_cols_reg;
    logic [hfps_pkg::COEF_W-1:0]      coef_x_reg;
    logic [hfps_pkg::COEF_W-1:0]      coef_y_reg;
    logic                             cfg_wr;
    hfps_pkg::reg_idx_t               cfg_idx;

    // Clamped frame size
    logic [31:0]       rows_ext;
    logic [31:0]       cols_ext;
    logic [31:0]       rows_lim;
    logic [31:0]       cols_lim;
    logic [ROW_W-1:0]  rows_p1;
    logic [ADDR_W-1:0] cols_eff;
    logic [ADDR_W-1:0] cols_p1;

    // Position and window
    logic                         clearing_reg;
    logic [ADDR_W-1:0]            clr_cnt_reg;
    logic [ADDR_W-1:0]            col_cnt_reg;
    logic [ROW_W-1:0]             row_cnt_reg;
    logic                         sel_shadow_reg;
    logic signed [TEMP_WIDTH-1:0] cen_cur_reg;
    logic signed [TEMP_WIDTH-1:0] left_reg;
    logic signed [TEMP_WIDTH-1:0] shadow_c0_reg;
    logic signed [TEMP_WIDTH-1:0] shadow_c1_reg;
    logic signed [TEMP_WIDTH-1:0] shadow_a0_reg;

    // Line memories
    logic signed [TEMP_WIDTH-1:0] mem_above  [LINE_DEPTH];
    logic signed [TEMP_WIDTH-1:0] mem_centre [LINE_DEPTH];
    logic signed [TEMP_WIDTH-1:0] q_above_reg;
    logic signed [TEMP_WIDTH-1:0] q_centre_reg;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic signed [TEMP_WIDTH-1:0] wr_above_data;
    logic signed [TEMP_WIDTH-1:0] wr_centre_data;
    logic [ADDR_W:0]              col_p1;
    logic [ADDR_W:0]              col_p2;
    logic                         rd_above_en;
    logic                         rd_centre_en;

    // Handshake and stencil control
    logic                         accept;
    logic                         advance;
    logic                         col_at_end;
    logic                         row_at_end;
    logic                         has_result;
    logic signed [TEMP_WIDTH-1:0] up_val;
    logic signed [TEMP_WIDTH-1:0] right_val;
    hfps_pkg::hfps_tag_t          tag_in;
    hfps_pkg::hfps_tag_t          tag_out;

    // APB decode
    assign pready  = 1'b1;
    assign cfg_idx = hfps_pkg::reg_idx_t'(paddr[hfps_pkg::REG_IDX_W+1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            hfps_pkg::REG_GRID_ROWS: prdata = hfps_pkg::PDATA_W'(grid_rows_reg);
            hfps_pkg::REG_GRID_COLS: prdata = hfps_pkg::PDATA_W'(grid_cols_reg);
            hfps_pkg::REG_COEF_X:    prdata = hfps_pkg::PDATA_W'(coef_x_reg);
            hfps_pkg::REG_COEF_Y:    prdata = hfps_pkg::PDATA_W'(coef_y_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= hfps_pkg::GRID_ROWS_RST;
            grid_cols_reg <= hfps_pkg::GRID_COLS_RST;
            coef_x_reg    <= hfps_pkg::COEF_RST;
            coef_y_reg    <= hfps_pkg::COEF_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                hfps_pkg::REG_GRID_ROWS:
                    grid_rows_reg <= pwdata[hfps_pkg::GRID_ROWS_W-1:0];
                hfps_pkg::REG_GRID_COLS:
                    grid_cols_reg <= pwdata[hfps_pkg::GRID_COLS_W-1:0];
                hfps_pkg::REG_COEF_X:
                    coef_x_reg <= pwdata[hfps_pkg::COEF_W-1:0];
                hfps_pkg::REG_COEF_Y:
                    coef_y_reg <= pwdata[hfps_pkg::COEF_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Clamp the frame size to the supported range
    always_comb
    begin
        rows_ext = 32'(grid_rows_reg);
        cols_ext = 32'(grid_cols_reg);
        if (rows_ext == 32'd0)
            rows_lim = 32'd1;
        else if (rows_ext > 32'(MAX_ROWS))
            rows_lim = 32'(MAX_ROWS);
        else
            rows_lim = rows_ext;
        if (cols_ext == 32'd0)
            cols_lim = 32'd1;
        else if (cols_ext > 32'(MAX_COLS))
            cols_lim = 32'(MAX_COLS);
        else
            cols_lim = cols_ext;
        rows_p1  = ROW_W'(rows_lim + 32'd1);
        cols_eff = ADDR_W'(cols_lim);
        cols_p1  = ADDR_W'(cols_lim + 32'd1);
    end

    // Transfer control: the update pipeline moves unless its output is stalled
    assign advance      = !tag_out.valid || result_ready;
    assign sample_ready = advance && !clearing_reg;
    assign accept       = sample_valid && sample_ready;

    assign col_at_end = (col_cnt_reg >= cols_p1);
    assign row_at_end = (row_cnt_reg >= rows_p1);
    assign has_result = (row_cnt_reg >= ROW_W'(2)) && (col_cnt_reg != '0)
                        && (col_cnt_reg <= cols_eff);

    // Window: after a row start, entries 0 and 1 come from their shadow copies
    assign up_val    = sel_shadow_reg ? shadow_a0_reg : q_above_reg;
    assign right_val = sel_shadow_reg ? shadow_c1_reg : q_centre_reg;

    always_comb
    begin
        tag_in.valid = accept && has_result;
        tag_in.last  = row_at_end && (col_cnt_reg == cols_eff);
    end

    // Memory ports: clear sweep or write-back of the current column
    assign wr_en          = clearing_reg || accept;
    assign wr_addr        = clearing_reg ? clr_cnt_reg : col_cnt_reg;
    assign wr_above_data  = clearing_reg ? '0 : cen_cur_reg;
    assign wr_centre_data = clearing_reg ? '0 : temp_in;

    // Prefetch the next column's above entry and the one after for the right tap
    assign col_p1       = {1'b0, col_cnt_reg} + (ADDR_W+1)'(1);
    assign col_p2       = {1'b0, col_cnt_reg} + (ADDR_W+1)'(2);
    assign rd_above_en  = accept && (col_p1 < (ADDR_W+1)'(LINE_DEPTH));
    assign rd_centre_en = accept && (col_p2 < (ADDR_W+1)'(LINE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_above[wr_addr] <= wr_above_data;
        end
        if (rd_above_en)
        begin
            q_above_reg <= mem_above[col_p1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_centre[wr_addr] <= wr_centre_data;
        end
        if (rd_centre_en)
        begin
            q_centre_reg <= mem_centre[col_p2[ADDR_W-1:0]];
        end
    end

    // Clear sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == CLR_LAST)
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // Shadow copies of line entries used at the start of a row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_c0_reg <= '0;
            shadow_c1_reg <= '0;
            shadow_a0_reg <= '0;
        end
        else if (accept)
        begin
            if (col_cnt_reg == ADDR_W'(0))
            begin
                shadow_c0_reg <= temp_in;
                shadow_a0_reg <= cen_cur_reg;
            end
            if (col_cnt_reg == ADDR_W'(1))
            begin
                shadow_c1_reg <= temp_in;
            end
        end
    end

    // Raster position and window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            sel_shadow_reg <= 1'b1;
            cen_cur_reg    <= '0;
            left_reg       <= '0;
        end
        else if (cfg_wr && (cfg_idx == hfps_pkg::REG_GRID_ROWS
                            || cfg_idx == hfps_pkg::REG_GRID_COLS))
        begin
            // restart the frame, keep line contents
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            sel_shadow_reg <= 1'b1;
            cen_cur_reg    <= shadow_c0_reg;
        end
        else if (accept)
        begin
            left_reg <= cen_cur_reg;
            if (col_at_end)
            begin
                col_cnt_reg    <= '0;
                row_cnt_reg    <= row_at_end ? '0 : row_cnt_reg + ROW_W'(1);
                sel_shadow_reg <= 1'b1;
                cen_cur_reg    <= shadow_c0_reg;
            end
            else
            begin
                col_cnt_reg    <= col_cnt_reg + ADDR_W'(1);
                sel_shadow_reg <= 1'b0;
                cen_cur_reg    <= right_val;
            end
        end
    end

    hfps_update #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .tag_in   (tag_in),
        .up       (up_val),
        .centre   (cen_cur_reg),
        .down     (temp_in),
        .left     (left_reg),
        .right    (right_val),
        .coef_x   (coef_x_reg),
        .coef_y   (coef_y_reg),
        .tag_out  (tag_out),
        .temp_out (temp_out)
    );

    assign result_valid = tag_out.valid;
    assign frame_last   = tag_out.last;

    // Column position never runs past the right halo column
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_cnt_reg <= cols_p1)
        else $error("column counter past right halo");

    // A transfer at the right halo column starts the next row from the shadows
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_at_end && !cfg_wr) |=> (sel_shadow_reg && col_cnt_reg == '0))
        else $error("row wrap did not select shadow window");

    // The clear sweep ends only after covering every line entry
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> (clr_cnt_reg == CLR_LAST))
        else $error("clear sweep ended early");

    // While the memories are being cleared, every write goes to the clear address
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !wr_en || wr_addr == clr_cnt_reg)
        else $error("write-back during clear sweep");

endmodule

`default_nettype wire
